// File: rtl/core/pge_pkg.sv
// Shared constants, a state type and a helper function of the phase gradient estimator.
package pge_pkg;

   // Default number of bins per frame; must be a power of two.
   localparam int PGE_BINS = 1024;

   localparam int PH_W  = 16;          // binary angle, 65536 is one turn
   localparam int HOP_W = 11;          // analysis hop register
   localparam int IDX_W = 10;          // bin index field of a result
   localparam int TD_W  = 26;          // time derivative field
   localparam int T_W   = PH_W + 8;    // scaled phase deviation per hop
   localparam int DVD_W = T_W - 1;     // magnitude fed to the divider

   localparam logic [HOP_W-1:0] HOP_RESET = HOP_W'(256);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_EMIT_PREV,
      ST_EMIT_LAST
   } pge_state_type;

   // Floor of the mean of two neighbor differences, or the one that is nonzero.
   function automatic logic signed [PH_W-1:0] pge_combine(
      input logic signed [PH_W-1:0] back,
      input logic signed [PH_W-1:0] fwd
   );
      logic signed [PH_W:0]   sum;
      logic signed [PH_W-1:0] res;
      sum = {back[PH_W-1], back} + {fwd[PH_W-1], fwd};
      if (back != '0 && fwd != '0) begin
         res = sum[PH_W:1];
      end else if (back != '0) begin
         res = back;
      end else begin
         res = fwd;
      end
      return res;
   endfunction

endpackage

// File: rtl/core/pge_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pge_ram #(
   parameter int WIDTH = pge_pkg::PH_W,
   parameter int DEPTH = pge_pkg::PGE_BINS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/pge_div.sv
// Radix-2 restoring divider for unsigned operands, one quotient bit per cycle.
module pge_div #(
   parameter int DVD_W = pge_pkg::DVD_W,
   parameter int DVS_W = pge_pkg::HOP_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;

   logic [DVS_W:0]   rem_shift;
   logic [DVS_W:0]   rem_diff;
   logic             fits;

   // The quotient register shifts the dividend out at the top and the new
   // quotient bits in at the bottom.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DVD_W-1]};
      fits      = rem_shift >= {1'b0, dvs_ff};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = busy_ff && (cnt_ff == CNT_LAST);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         quo_in = {quo_ff[DVD_W-2:0], fits};
         rem_in = fits ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/phase_gradient_estimator_unit.sv
// Phase gradient estimator: time and frequency phase derivatives of spectral bins.
// Throughput: one request at a time; a request passes through accept, setup, a
// bit-serial divide by the hop, the divider handshake and result emission, with
// a second result for the last bin of a frame.
// Results lag one bin; a result slot that is stalled adds its stall cycles.
// Reset (synchronous, active high) clears the control state, restores the hop
// register to 256 and marks the first frame so that previous phases read as zero.
module phase_gradient_estimator_unit #(
   parameter int BINS = pge_pkg::PGE_BINS
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [pge_pkg::PH_W-1:0]   req_bin_phase,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic        [pge_pkg::IDX_W-1:0]  rsp_bin_index,
   output logic signed [pge_pkg::TD_W-1:0]   rsp_time_deriv,
   output logic signed [pge_pkg::PH_W-1:0]   rsp_freq_deriv,
   output logic                              rsp_last_of_frame,

   input  logic                              csr_write_en,
   input  logic        [pge_pkg::HOP_W-1:0]  csr_write_data
);

   import pge_pkg::*;

   // BINS is a power of two, so the expected phase advance of bin k over one
   // hop, hop*k*65536/BINS, only matters through the low bits of hop*k.
   localparam int BIN_W     = $clog2(BINS);
   localparam int R_W       = PH_W + BIN_W;
   localparam int PROD_W    = HOP_W + BIN_W;
   localparam int CENTER_SH = T_W - BIN_W;
   localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BINS - 1);

   pge_state_type state_ff, state_in;

   logic [BIN_W-1:0]        counter_ff, counter_in;
   logic                    first_frame_ff, first_frame_in;
   logic [HOP_W-1:0]        hop_ff, hop_in;
   logic signed [PH_W-1:0]  prev_bin_ff, prev_bin_in;
   logic signed [PH_W-1:0]  pend_back_ff, pend_back_in;
   logic signed [TD_W-1:0]  pend_td_ff, pend_td_in;

   logic [BIN_W-1:0]        k_ff, k_in;
   logic signed [PH_W-1:0]  pdiff_ff, pdiff_in;
   logic signed [PH_W-1:0]  back_ff, back_in;
   logic                    neg_ff, neg_in;
   logic signed [TD_W-1:0]  td_ff, td_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic signed [TD_W-1:0]  rsp_td_ff, rsp_td_in;
   logic signed [PH_W-1:0]  rsp_fd_ff, rsp_fd_in;
   logic                    rsp_last_ff, rsp_last_in;

   // State machine outputs.
   logic                    accept;
   logic                    div_start;
   logic                    rsp_load;
   logic                    pend_load;
   logic                    slot_free;

   // Datapath nets.
   logic [HOP_W-1:0]        hop_eff;
   logic signed [PH_W-1:0]  prev_frame_phase;
   logic [PH_W-1:0]         ram_rd_data;
   logic [PROD_W-1:0]       prod;
   logic [R_W-1:0]          dev;
   logic [R_W+7:0]          dev_scaled;
   logic signed [T_W-1:0]   dev_per_bin;
   logic [DVD_W-1:0]        div_dividend;
   logic                    div_done;
   logic [DVD_W-1:0]        div_quotient;
   logic signed [T_W-1:0]   quo_signed;

   // ------------------------------------------------------------------
   // Phase memory of the previous frame. The read address follows the bin
   // counter, so the entry for the next request is ready well before the
   // state machine returns to idle. The entry is overwritten on accept.
   // ------------------------------------------------------------------
   pge_ram #(
      .WIDTH (PH_W),
      .DEPTH (BINS)
   ) u_phase_mem (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (counter_ff),
      .wr_data (req_bin_phase),
      .rd_addr (counter_ff),
      .rd_data (ram_rd_data)
   );

   // During the first frame after reset the memory holds nothing yet; every
   // entry is written before it is read in the second frame, so one flag
   // stands in for clearing the memory.
   assign prev_frame_phase = first_frame_ff ? '0 : signed'(ram_rd_data);

   // A hop of zero is treated as one.
   assign hop_eff = (hop_ff == '0) ? HOP_W'(1) : hop_ff;

   // ------------------------------------------------------------------
   // Setup step: the wrapped deviation is the phase advance scaled by BINS
   // minus the expected advance, taken modulo 65536*BINS. In two's complement
   // at R_W bits this wrap is free, and a tie lands on the negative half turn.
   // The deviation is then scaled by 256/BINS (a floor shift) before the
   // divide by the hop.
   // ------------------------------------------------------------------
   always_comb begin
      prod         = PROD_W'(hop_eff) * PROD_W'(k_ff);
      dev          = {pdiff_ff, {BIN_W{1'b0}}} - {prod[BIN_W-1:0], {PH_W{1'b0}}};
      dev_scaled   = {dev, 8'b0};
      dev_per_bin  = signed'(dev_scaled[R_W+7:BIN_W]);
      // Floor division of a negative value: floor(t/h) = ~(~t / h).
      div_dividend = dev_per_bin[T_W-1] ? ~dev_per_bin[DVD_W-1:0]
                                        : dev_per_bin[DVD_W-1:0];
   end

   pge_div #(
      .DVD_W (DVD_W),
      .DVS_W (HOP_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (hop_eff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // The bin center frequency, 65536*k/BINS with 8 fraction bits, is an exact
   // shift of the bin index and is added to the floored quotient.
   assign quo_signed = neg_ff ? ~signed'({1'b0, div_quotient})
                              : signed'({1'b0, div_quotient});

   // ------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_EMIT_PREV;
            end
         end
         ST_EMIT_PREV: begin
            // The first bin of a frame has no earlier bin to report.
            if (k_ff == '0 || slot_free) begin
               state_in = (k_ff == BIN_LAST) ? ST_EMIT_LAST : ST_IDLE;
            end
         end
         ST_EMIT_LAST: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      pend_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_PREP: begin
            div_start = 1'b1;
         end
         ST_DIV: begin
         end
         ST_EMIT_PREV: begin
            rsp_load  = (k_ff != '0) && slot_free;
            pend_load = (k_ff != BIN_LAST) && (k_ff == '0 || slot_free);
         end
         ST_EMIT_LAST: begin
            rsp_load = slot_free;
         end
         default: begin
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // Next values.
   // ------------------------------------------------------------------
   always_comb begin
      counter_in     = counter_ff;
      first_frame_in = first_frame_ff;
      prev_bin_in    = prev_bin_ff;
      k_in           = k_ff;
      pdiff_in       = pdiff_ff;
      back_in        = back_ff;
      if (accept) begin
         k_in        = counter_ff;
         pdiff_in    = req_bin_phase - prev_frame_phase;
         back_in     = (counter_ff == '0) ? '0 : req_bin_phase - prev_bin_ff;
         prev_bin_in = req_bin_phase;
         if (counter_ff == BIN_LAST) begin
            counter_in     = '0;
            first_frame_in = 1'b0;
         end else begin
            counter_in = counter_ff + BIN_W'(1);
         end
      end
   end

   assign hop_in = csr_write_en ? csr_write_data : hop_ff;
   assign neg_in = (state_ff == ST_PREP) ? dev_per_bin[T_W-1] : neg_ff;
   assign td_in  = (state_ff == ST_DIV && div_done)
                   ? (TD_W'(k_ff) << CENTER_SH)
                     + {{(TD_W - T_W){quo_signed[T_W-1]}}, quo_signed}
                   : td_ff;

   assign pend_td_in   = pend_load ? td_ff : pend_td_ff;
   assign pend_back_in = pend_load ? back_ff : pend_back_ff;

   // Result register: the earlier bin is completed by this bin's backward
   // difference; the last bin of a frame has no forward neighbor.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_td_in    = rsp_td_ff;
      rsp_fd_in    = rsp_fd_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (state_ff == ST_EMIT_LAST) begin
            rsp_index_in = IDX_W'(k_ff);
            rsp_td_in    = td_ff;
            rsp_fd_in    = pge_combine(back_ff, '0);
            rsp_last_in  = 1'b1;
         end else begin
            rsp_index_in = IDX_W'(k_ff - BIN_W'(1));
            rsp_td_in    = pend_td_ff;
            rsp_fd_in    = pge_combine(pend_back_ff, back_ff);
            rsp_last_in  = 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         counter_ff     <= '0;
         first_frame_ff <= 1'b1;
         hop_ff         <= HOP_RESET;
         prev_bin_ff    <= '0;
         pend_back_ff   <= '0;
         pend_td_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         counter_ff     <= counter_in;
         first_frame_ff <= first_frame_in;
         hop_ff         <= hop_in;
         prev_bin_ff    <= prev_bin_in;
         pend_back_ff   <= pend_back_in;
         pend_td_ff     <= pend_td_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      k_ff         <= k_in;
      pdiff_ff     <= pdiff_in;
      back_ff      <= back_in;
      neg_ff       <= neg_in;
      td_ff        <= td_in;
      rsp_index_ff <= rsp_index_in;
      rsp_td_ff    <= rsp_td_in;
      rsp_fd_ff    <= rsp_fd_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bin_index     = rsp_index_ff;
   assign rsp_time_deriv    = rsp_td_ff;
   assign rsp_freq_deriv    = rsp_fd_ff;
   assign rsp_last_of_frame = rsp_last_ff;

`ifndef SYNTH
   // The divider only finishes while the sequencer waits for it.
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside of the divide state");

   // A finished divide always moves on to result emission.
   a_div_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_done) |=> state_ff == ST_EMIT_PREV)
      else $error("divide result not taken");

   // Accepting the last bin wraps the counter and ends the first frame.
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && counter_ff == BIN_LAST) |=> (counter_ff == '0 && !first_frame_ff))
      else $error("bin counter did not wrap at end of frame");

   // The frame marker only accompanies the result of the last bin.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> rsp_index_ff == IDX_W'(BIN_LAST))
      else $error("frame marker on a result that is not the last bin");
`endif

endmodule

// File: tb/sv/tb_phase_gradient_estimator_unit.sv
// Self-checking testbench of the phase gradient estimator unit.
`timescale 1ns / 100ps

module tb_phase_gradient_estimator_unit;

   // The block is tested at its default frame size. One whole frame and most
   // of a second are sent so that the frame end is seen and the second frame
   // is estimated against real previous-frame phases instead of the cleared
   // store.
   localparam int BINS       = pge_pkg::PGE_BINS;
   localparam int DIR_ROWS   = 18;
   localparam int RAND_ITEMS = 1600 - DIR_ROWS;
   localparam int NUM_PHASES = 10;

   // A request that produces no result still needs time to finish inside the
   // block; the quiet cycles after draining give it that time.
   localparam int SETTLE_CYCLES = 40;
   localparam int IDLE_LIMIT    = 4000;

   // Hop value written before each random phase. A negative entry asks for a
   // random legal hop. Zero, one, the largest legal hop and values beyond it
   // are all visited.
   localparam int HOP_PLAN [NUM_PHASES] = '{0, 1, 1024, 2047, 1025, -1, 3, -1, 512, 100};
   localparam logic [pge_pkg::HOP_W-1:0] HOP_AFTER_RESET = 11'd256;

   // One expected result of the estimator.
   typedef struct packed {
      logic        [pge_pkg::IDX_W-1:0] idx;
      logic signed [pge_pkg::TD_W-1:0]  td;
      logic signed [pge_pkg::PH_W-1:0]  fd;
      logic                             last;
   } bin_result_type;

   // One row of the directed table. When typed is set, the first result that
   // the row causes is checked against want instead of the predictor.
   typedef struct packed {
      logic signed [pge_pkg::PH_W-1:0] ph;
      logic                            typed;
      bin_result_type                  want;
   } dir_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic signed [pge_pkg::PH_W-1:0]    req_bin_phase = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic        [pge_pkg::IDX_W-1:0]   rsp_bin_index;
   logic signed [pge_pkg::TD_W-1:0]    rsp_time_deriv;
   logic signed [pge_pkg::PH_W-1:0]    rsp_freq_deriv;
   logic                               rsp_last_of_frame;
   logic                               csr_write_en = 1'b0;
   logic        [pge_pkg::HOP_W-1:0]   csr_write_data = '0;

   // Predictor state: the phase of every bin in the previous frame, the phase
   // of the bin just seen, and the half-finished result of that bin, which
   // waits for the forward neighbor before it can be completed.
   logic signed [pge_pkg::PH_W-1:0]    prev_frame_ph [BINS];
   logic signed [pge_pkg::PH_W-1:0]    prev_bin_ph;
   logic signed [pge_pkg::PH_W-1:0]    pend_back;
   logic signed [pge_pkg::TD_W-1:0]    pend_td;
   int                                 bin_cnt;
   logic        [pge_pkg::HOP_W-1:0]   hop_reg;

   bin_result_type                     expected_q [$];

   int  mismatches    = 0;
   int  requests_sent = 0;
   int  results_seen  = 0;
   int  frame_ends    = 0;
   int  hops_used     = 1;
   int  idle_cycles   = 0;
   int  req_gap_odds  = 0;
   int  rsp_gap_odds  = 0;
   int  rsp_hold      = 0;

   // Directed requests, sent from bin 0 of the first frame with the reset hop
   // of 256. The first few results follow directly from the cleared store:
   // zero phases give zero frequency, a full positive step to the next bin
   // gives the largest forward difference, and the step from the largest
   // positive to the most negative angle wraps to a difference of one.
   // Further rows hit the half-turn ties: a neighbor difference of exactly
   // half a turn, and a phase that sits half a turn from the expected
   // advance (bins 8 and 10 with this hop).
   dir_row_type directed_rows [DIR_ROWS] = '{
      '{16'sh0000, 1'b0, '0},
      '{16'sh0000, 1'b1, '{10'd0, 26'sd0, 16'sd0, 1'b0}},
      '{16'sh7FFF, 1'b1, '{10'd1, 26'sd0, 16'sh7FFF, 1'b0}},
      '{16'sh8000, 1'b1, '{10'd2, 26'sd32767, 16'sd16384, 1'b0}},
      '{16'sh8000, 1'b0, '0},
      '{16'sh0000, 1'b0, '0},
      '{16'sh8000, 1'b0, '0},
      '{16'sh0001, 1'b0, '0},
      '{16'sh8000, 1'b0, '0},
      '{16'shFFFF, 1'b0, '0},
      '{16'sh0000, 1'b0, '0},
      '{16'sh5555, 1'b0, '0},
      '{16'shAAAA, 1'b0, '0},
      '{16'sd100,  1'b0, '0},
      '{16'sd100,  1'b0, '0},
      '{-16'sd100, 1'b0, '0},
      '{16'sh7FFF, 1'b0, '0},
      '{16'sh0000, 1'b0, '0}
   };

   phase_gradient_estimator_unit #(
      .BINS(BINS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_bin_phase     (req_bin_phase),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_bin_index     (rsp_bin_index),
      .rsp_time_deriv    (rsp_time_deriv),
      .rsp_freq_deriv    (rsp_freq_deriv),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // Floor of the mean of the backward and forward differences when both are
   // nonzero, otherwise whichever one is nonzero (or zero).
   function automatic logic signed [pge_pkg::PH_W-1:0] neighbor_mean(
      input logic signed [pge_pkg::PH_W-1:0] a,
      input logic signed [pge_pkg::PH_W-1:0] b
   );
      longint s;
      s = longint'(a) + longint'(b);
      if (a != 0 && b != 0) begin
         return 16'(s >>> 1);
      end
      return (a != 0) ? a : b;
   endfunction

   // Works out the results that one accepted bin phase causes, and advances
   // the predictor state exactly as the block is expected to.
   task automatic estimate_gradients(
      input  logic signed [pge_pkg::PH_W-1:0] ph,
      output bin_result_type                  res [2],
      output int                              n
   );
      longint k, hop, m, v, r, num, den, q;
      logic signed [pge_pkg::PH_W-1:0] back;
      logic signed [pge_pkg::TD_W-1:0] td;
      k   = bin_cnt;
      hop = (hop_reg == 0) ? 1 : longint'(hop_reg);
      n   = 0;
      // Phase advance against the previous frame, less the advance that the
      // bin center frequency predicts, wrapped into the half-open turn
      // [-half, +half). Everything is scaled by BINS to stay in integers.
      m = 64'd65536 * BINS;
      v = (longint'(ph) - longint'(prev_frame_ph[k])) * BINS - hop * k * 65536;
      r = v % m;
      if (r < 0) r = r + m;
      if (r >= m / 2) r = r - m;
      // Deviation per sample plus the bin center, 8 fraction bits, floored.
      num = r * 256 + k * hop * 64'd16777216;
      den = BINS * hop;
      q   = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      td   = 26'(q);
      back = (k > 0) ? ph - prev_bin_ph : 16'sd0;
      if (k > 0) begin
         res[n] = '{10'(k - 1), pend_td, neighbor_mean(pend_back, back), 1'b0};
         n++;
      end
      if (k == BINS - 1) begin
         res[n] = '{10'(k), td, neighbor_mean(back, 16'sd0), 1'b1};
         n++;
         bin_cnt = 0;
      end else begin
         pend_td   = td;
         pend_back = back;
         bin_cnt   = int'(k) + 1;
      end
      prev_bin_ph       = ph;
      prev_frame_ph[k]  = ph;
   endtask

   // Random phase for the next bin. Plain random angles are mixed with tonal
   // bins that sit near the expected advance, steady neighbors, extremes and
   // exact half-turn ties, so that both derivatives see small values and
   // every wrap case, not only noise.
   function automatic logic signed [pge_pkg::PH_W-1:0] pick_phase();
      logic signed [pge_pkg::PH_W-1:0] center_ph;
      int hop_eff;
      hop_eff   = (hop_reg == 0) ? 1 : int'(hop_reg);
      center_ph = prev_frame_ph[bin_cnt] + 16'(hop_eff * bin_cnt * (65536 / BINS));
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'($urandom);
         4, 5:       return center_ph + 16'($urandom_range(0, 128)) - 16'sd64;
         6: begin
            case ($urandom_range(0, 3))
               0:       return 16'sh8000;
               1:       return 16'sh7FFF;
               2:       return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
         7:          return prev_bin_ph + 16'($urandom_range(0, 64)) - 16'sd32;
         8:          return center_ph + 16'sh8000;
         default:    return prev_bin_ph;
      endcase
   endfunction

   // Presents one bin phase request, waits for the block to take it and
   // records what it should produce. Called right after a rising edge. The
   // sender may first idle for one short burst.
   task automatic send_bin(
      input logic signed [pge_pkg::PH_W-1:0] ph,
      input logic                            typed,
      input bin_result_type                  want
   );
      bin_result_type res [2];
      int n;
      if (req_gap_odds != 0 && $urandom_range(1, req_gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_bin_phase <= ph;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      estimate_gradients(ph, res, n);
      for (int i = 0; i < n; i++) begin
         expected_q.push_back((typed && i == 0) ? want : res[i]);
      end
   endtask

   // Stops sending and lets every outstanding result come back, then gives a
   // request that causes no result time to leave the block as well.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_hop(input logic [pge_pkg::HOP_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      hop_reg = value;
      hops_used++;
   endtask

   // The result side stalls in random bursts while its odds are nonzero.
   always @(posedge clock) begin
      if (rsp_hold == 0 && rsp_gap_odds != 0 && $urandom_range(1, rsp_gap_odds) == 1) begin
         rsp_hold = $urandom_range(1, 12);
      end
      if (rsp_hold != 0) begin
         rsp_stall <= 1'b1;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Every accepted result is compared field by field with the oldest
   // expectation.
   always @(posedge clock) begin : check_results
      bin_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_last_of_frame === 1'b1) frame_ends++;
         if (expected_q.size() == 0) begin
            flag_mismatch($sformatf("result for bin %0d with nothing expected", rsp_bin_index));
         end else begin
            want = expected_q.pop_front();
            if (rsp_bin_index !== want.idx) begin
               flag_mismatch($sformatf("bin index %0d, expected %0d",
                                       rsp_bin_index, want.idx));
            end
            if (rsp_time_deriv !== want.td) begin
               flag_mismatch($sformatf("bin %0d time derivative %0d, expected %0d",
                                       want.idx, rsp_time_deriv, want.td));
            end
            if (rsp_freq_deriv !== want.fd) begin
               flag_mismatch($sformatf("bin %0d frequency derivative %0d, expected %0d",
                                       want.idx, rsp_freq_deriv, want.fd));
            end
            if (rsp_last_of_frame !== want.last) begin
               flag_mismatch($sformatf("bin %0d last of frame %0b, expected %0b",
                                       want.idx, rsp_last_of_frame, want.last));
            end
         end
      end
   end

   // Watchdog: the run ends if nothing at all is accepted for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("timeout: no request or result accepted for %0d cycles", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int hop_value;
      int sent;
      // The predictor starts from the reset state of the block: cleared phase
      // store, counter at bin 0 and the default hop.
      for (int i = 0; i < BINS; i++) prev_frame_ph[i] = '0;
      prev_bin_ph = '0;
      pend_back   = '0;
      pend_td     = '0;
      bin_cnt     = 0;
      hop_reg     = HOP_AFTER_RESET;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table with light idling on both sides.
      req_gap_odds = 4;
      rsp_gap_odds = 6;
      for (int i = 0; i < DIR_ROWS; i++) begin
         send_bin(directed_rows[i].ph, directed_rows[i].typed, directed_rows[i].want);
      end

      // Random phases. Each phase starts from an idle block with a new hop;
      // the frame keeps running across hop changes, as it would in use.
      sent = 0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_block();
         hop_value = (HOP_PLAN[p] < 0) ? $urandom_range(1, 1024) : HOP_PLAN[p];
         write_hop(11'(hop_value));
         // Some phases run without idling; the last one always does.
         if (p == NUM_PHASES - 1 || p % 4 == 2) begin
            req_gap_odds = 0;
            rsp_gap_odds = 0;
         end else begin
            req_gap_odds = $urandom_range(2, 8);
            rsp_gap_odds = $urandom_range(3, 20);
         end
         while (sent < (p + 1) * RAND_ITEMS / NUM_PHASES) begin
            send_bin(pick_phase(), 1'b0, '0);
            sent++;
         end
      end

      drain_block();
      if (expected_q.size() != 0) begin
         flag_mismatch($sformatf("%0d results never arrived", expected_q.size()));
      end

      $display("Sent %0d bin phase requests under %0d hop settings,",
               requests_sent, hops_used);
      $display("including zero and out-of-range hops; checked %0d results across %0d frame ends.",
               results_seen, frame_ends);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/pge_pkg.sv
rtl/core/pge_ram.sv
rtl/core/pge_div.sv
rtl/core/phase_gradient_estimator_unit.sv
tb/sv/tb_phase_gradient_estimator_unit.sv
